// ----- rtl/dhfk_pkg.sv -----
package dhfk_pkg;

    localparam int MAX_JOINTS   = 4;
    localparam int NUM_LANES    = 2 * MAX_JOINTS;  // theta lanes 0..3, twist lanes 4..7
    localparam int CORDIC_STEPS = 16;
    localparam int CORDIC_FRAC  = 30;
    localparam int XW           = 33;              // CORDIC x/y iterate width
    localparam int ZW           = 17;              // residual angle width
    localparam int QW           = 17;              // link offset, Q.15 with headroom
    localparam int PW           = 22;              // running position, Q.15
    localparam int CW           = 3;               // config index width
    localparam int ANG_W        = 16;
    localparam int OUT_W        = 208;

    localparam logic signed [XW-1:0] CORDIC_GAIN = 33'sd652032874;

    localparam logic signed [ZW-1:0] ATAN_STEPS [CORDIC_STEPS] = '{
        17'sd8192, 17'sd4836, 17'sd2555, 17'sd1297, 17'sd651, 17'sd326, 17'sd163, 17'sd81,
        17'sd41,   17'sd20,   17'sd10,   17'sd5,    17'sd3,   17'sd1,   17'sd1,   17'sd0
    };

    localparam logic [CW-1:0] REG_DH_JOINT_0 = 3'd0;
    localparam logic [CW-1:0] REG_DH_JOINT_1 = 3'd1;
    localparam logic [CW-1:0] REG_DH_JOINT_2 = 3'd2;
    localparam logic [CW-1:0] REG_DH_JOINT_3 = 3'd3;
    localparam logic [CW-1:0] REG_FRAMES     = 3'd4;

    typedef struct packed {
        logic       valid;
        logic [2:0] frames;   // frames chained for this beat, already limited
    } t_ctl;

endpackage

// ----- rtl/dhfk_cordic_cell.sv -----
module dhfk_cordic_cell #(
    parameter int STEP = 0
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_en,
    input  dhfk_pkg::t_ctl                 i_ctl,
    input  logic [dhfk_pkg::NUM_LANES-1:0] i_flip,
    input  logic signed [dhfk_pkg::XW-1:0] i_x [dhfk_pkg::NUM_LANES],
    input  logic signed [dhfk_pkg::XW-1:0] i_y [dhfk_pkg::NUM_LANES],
    input  logic signed [dhfk_pkg::ZW-1:0] i_z [dhfk_pkg::NUM_LANES],
    output dhfk_pkg::t_ctl                 o_ctl,
    output logic [dhfk_pkg::NUM_LANES-1:0] o_flip,
    output logic signed [dhfk_pkg::XW-1:0] o_x [dhfk_pkg::NUM_LANES],
    output logic signed [dhfk_pkg::XW-1:0] o_y [dhfk_pkg::NUM_LANES],
    output logic signed [dhfk_pkg::ZW-1:0] o_z [dhfk_pkg::NUM_LANES]
);
    import dhfk_pkg::*;

    localparam logic signed [ZW-1:0] ATAN = ATAN_STEPS[STEP];

    t_ctl                   r_ctl;
    logic [NUM_LANES-1:0]   r_flip;
    logic signed [XW-1:0]   r_x [NUM_LANES];
    logic signed [XW-1:0]   r_y [NUM_LANES];
    logic signed [ZW-1:0]   r_z [NUM_LANES];
    logic signed [XW-1:0]   n_x [NUM_LANES];
    logic signed [XW-1:0]   n_y [NUM_LANES];
    logic signed [ZW-1:0]   n_z [NUM_LANES];

    always_comb begin
        for (int l = 0; l < NUM_LANES; l++) begin
            if (!i_z[l][ZW-1]) begin
                n_x[l] = i_x[l] - (i_y[l] >>> STEP);
                n_y[l] = i_y[l] + (i_x[l] >>> STEP);
                n_z[l] = i_z[l] - ATAN;
            end else begin
                n_x[l] = i_x[l] + (i_y[l] >>> STEP);
                n_y[l] = i_y[l] - (i_x[l] >>> STEP);
                n_z[l] = i_z[l] + ATAN;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else if (i_en) begin
            r_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_flip <= i_flip;
            r_x    <= n_x;
            r_y    <= n_y;
            r_z    <= n_z;
        end
    end

    assign o_ctl  = r_ctl;
    assign o_flip = r_flip;
    assign o_x    = r_x;
    assign o_y    = r_y;
    assign o_z    = r_z;

endmodule

// ----- rtl/dhfk_joint_cell.sv -----
module dhfk_joint_cell #(
    parameter  int FRAC_BITS = 14,
    parameter  int JOINT     = 0,
    localparam int TW        = FRAC_BITS + 2
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_en,
    input  dhfk_pkg::t_ctl                 i_ctl,
    input  logic signed [15:0]             i_a,
    input  logic signed [15:0]             i_d,
    input  logic signed [TW-1:0]           i_t  [9],
    input  logic signed [dhfk_pkg::PW-1:0] i_p  [3],
    input  logic signed [TW-1:0]           i_st [dhfk_pkg::MAX_JOINTS],
    input  logic signed [TW-1:0]           i_ct [dhfk_pkg::MAX_JOINTS],
    input  logic signed [TW-1:0]           i_sa [dhfk_pkg::MAX_JOINTS],
    input  logic signed [TW-1:0]           i_ca [dhfk_pkg::MAX_JOINTS],
    output dhfk_pkg::t_ctl                 o_ctl,
    output logic signed [TW-1:0]           o_t  [9],
    output logic signed [dhfk_pkg::PW-1:0] o_p  [3],
    output logic signed [TW-1:0]           o_st [dhfk_pkg::MAX_JOINTS],
    output logic signed [TW-1:0]           o_ct [dhfk_pkg::MAX_JOINTS],
    output logic signed [TW-1:0]           o_sa [dhfk_pkg::MAX_JOINTS],
    output logic signed [TW-1:0]           o_ca [dhfk_pkg::MAX_JOINTS]
);
    import dhfk_pkg::*;

    localparam int PR  = 2 * TW;
    localparam int AR  = 16 + TW;
    localparam int SW  = 2 * TW + 2;
    localparam int PSW = TW + QW + 2;
    localparam logic signed [PR-1:0]  HALF_PR  = PR'(1)  <<< (FRAC_BITS - 1);
    localparam logic signed [AR-1:0]  HALF_AR  = AR'(1)  <<< (FRAC_BITS - 1);
    localparam logic signed [SW-1:0]  HALF_SW  = SW'(1)  <<< (FRAC_BITS - 1);
    localparam logic signed [PSW-1:0] HALF_PSW = PSW'(1) <<< (FRAC_BITS - 1);

    // stage A: DH matrix of this joint
    t_ctl                  r_a_ctl;
    logic signed [TW-1:0]  r_a_t [9];
    logic signed [PW-1:0]  r_a_p [3];
    logic signed [TW-1:0]  r_a_m [9];
    logic signed [QW-1:0]  r_a_q [3];
    logic signed [TW-1:0]  r_a_st [MAX_JOINTS];
    logic signed [TW-1:0]  r_a_ct [MAX_JOINTS];
    logic signed [TW-1:0]  r_a_sa [MAX_JOINTS];
    logic signed [TW-1:0]  r_a_ca [MAX_JOINTS];
    logic signed [TW-1:0]  n_a_m [9];
    logic signed [QW-1:0]  n_a_q [3];

    // stage B: running product
    t_ctl                  r_b_ctl;
    logic signed [TW-1:0]  r_b_t [9];
    logic signed [PW-1:0]  r_b_p [3];
    logic signed [TW-1:0]  r_b_st [MAX_JOINTS];
    logic signed [TW-1:0]  r_b_ct [MAX_JOINTS];
    logic signed [TW-1:0]  r_b_sa [MAX_JOINTS];
    logic signed [TW-1:0]  r_b_ca [MAX_JOINTS];
    logic signed [TW-1:0]  n_b_t [9];
    logic signed [PW-1:0]  n_b_p [3];

    function automatic logic signed [TW-1:0] rnd_pr(input logic signed [PR-1:0] v);
        logic signed [PR-1:0] s;
        s = (v + HALF_PR) >>> FRAC_BITS;
        return s[TW-1:0];
    endfunction

    function automatic logic signed [QW-1:0] rnd_ar(input logic signed [AR-1:0] v);
        logic signed [AR-1:0] s;
        s = (v + HALF_AR) >>> FRAC_BITS;
        return s[QW-1:0];
    endfunction

    always_comb begin
        logic signed [TW-1:0] st, ct, sa, ca;
        st = i_st[JOINT];
        ct = i_ct[JOINT];
        sa = i_sa[JOINT];
        ca = i_ca[JOINT];
        n_a_m[0] = ct;
        n_a_m[1] = -rnd_pr(PR'(st) * PR'(ca));
        n_a_m[2] = rnd_pr(PR'(st) * PR'(sa));
        n_a_m[3] = st;
        n_a_m[4] = rnd_pr(PR'(ct) * PR'(ca));
        n_a_m[5] = -rnd_pr(PR'(ct) * PR'(sa));
        n_a_m[6] = '0;
        n_a_m[7] = sa;
        n_a_m[8] = ca;
        n_a_q[0] = rnd_ar(AR'(i_a) * AR'(ct));
        n_a_q[1] = rnd_ar(AR'(i_a) * AR'(st));
        n_a_q[2] = QW'(i_d);
    end

    always_comb begin
        logic signed [SW-1:0]  s;
        logic signed [PSW-1:0] ps;
        logic                  act;
        act = 3'(JOINT) < r_a_ctl.frames;
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                s = '0;
                for (int k = 0; k < 3; k++) begin
                    s = s + SW'(r_a_t[3*r+k]) * SW'(r_a_m[3*k+c]);
                end
                s = (s + HALF_SW) >>> FRAC_BITS;
                n_b_t[3*r+c] = act ? s[TW-1:0] : r_a_t[3*r+c];
            end
            ps = '0;
            for (int k = 0; k < 3; k++) begin
                ps = ps + PSW'(r_a_t[3*r+k]) * PSW'(r_a_q[k]);
            end
            ps = (ps + HALF_PSW) >>> FRAC_BITS;
            n_b_p[r] = act ? (PW'(ps) + r_a_p[r]) : r_a_p[r];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_ctl <= '0;
            r_b_ctl <= '0;
        end else if (i_en) begin
            r_a_ctl <= i_ctl;
            r_b_ctl <= r_a_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_t  <= i_t;
            r_a_p  <= i_p;
            r_a_m  <= n_a_m;
            r_a_q  <= n_a_q;
            r_a_st <= i_st;
            r_a_ct <= i_ct;
            r_a_sa <= i_sa;
            r_a_ca <= i_ca;
            r_b_t  <= n_b_t;
            r_b_p  <= n_b_p;
            r_b_st <= r_a_st;
            r_b_ct <= r_a_ct;
            r_b_sa <= r_a_sa;
            r_b_ca <= r_a_ca;
        end
    end

    assign o_ctl = r_b_ctl;
    assign o_t   = r_b_t;
    assign o_p   = r_b_p;
    assign o_st  = r_b_st;
    assign o_ct  = r_b_ct;
    assign o_sa  = r_b_sa;
    assign o_ca  = r_b_ca;

endmodule

// ----- rtl/dh_forward_kinematics.sv -----
// DH forward kinematics: four joint angles in, rotation and position out.
// Pipeline: 16 CORDIC cells, 1 trig rounding stage, 2 stages per joint cell
//   and 1 output stage.
// Throughput: one beat per cycle; the whole chain advances together and
//   stalls only while the output register holds a beat not yet taken.
// Reset (i_rst_n low, synchronous): valid flags clear, DH registers reload
//   their defaults; no clearing pass.
module dh_forward_kinematics #(
    parameter int NUM_JOINTS = 4,
    parameter int FRAC_BITS  = 14
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // config write port
    input  logic                              i_cfg_we,
    input  logic [dhfk_pkg::CW-1:0]           i_cfg_addr,
    input  logic [63:0]                       i_cfg_data,
    // input beats
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    // joint_angle_0 [15:0], joint_angle_1 [31:16], joint_angle_2 [47:32],
    // joint_angle_3 [63:48]
    input  logic [63:0]                       i_s_tdata,
    // output beats
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    // rot_00 [15:0], rot_01 [31:16], rot_02 [47:32], pos_x [66:48],
    // rot_10 [82:67], rot_11 [98:83], rot_12 [114:99], pos_y [133:115],
    // rot_20 [149:134], rot_21 [165:150], rot_22 [181:166], pos_z [200:182],
    // zero pad [207:201]
    output logic [dhfk_pkg::OUT_W-1:0]        o_m_tdata
);
    import dhfk_pkg::*;

    localparam int TW = FRAC_BITS + 2;
    localparam int RS = CORDIC_FRAC - FRAC_BITS;
    localparam logic signed [XW-1:0] HALF_C = XW'(1) <<< (RS - 1);
    localparam logic signed [TW-1:0] ONE    = TW'(1) <<< FRAC_BITS;
    localparam int VW = TW + 8;

    // ---------------- configuration ----------------
    logic [63:0] r_dh [MAX_JOINTS];
    logic [2:0]  r_frames;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dh[0]  <= 64'd10560250839040;
            r_dh[1]  <= 64'd4260;
            r_dh[2]  <= 64'd4063;
            r_dh[3]  <= 64'd2294;
            r_frames <= 3'd4;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                REG_DH_JOINT_0: r_dh[0]  <= i_cfg_data;
                REG_DH_JOINT_1: r_dh[1]  <= i_cfg_data;
                REG_DH_JOINT_2: r_dh[2]  <= i_cfg_data;
                REG_DH_JOINT_3: r_dh[3]  <= i_cfg_data;
                REG_FRAMES:     r_frames <= i_cfg_data[2:0];
                default: ;
            endcase
        end
    end

    // global advance: whole chain moves unless a result is waiting
    logic en;
    logic r_out_valid;
    assign en         = !r_out_valid || i_m_tready;
    assign o_s_tready = en;

    // ---------------- CORDIC lanes ----------------
    t_ctl                 w_cctl [CORDIC_STEPS+1];
    logic [NUM_LANES-1:0] w_flip [CORDIC_STEPS+1];
    logic signed [XW-1:0] w_x [CORDIC_STEPS+1][NUM_LANES];
    logic signed [XW-1:0] w_y [CORDIC_STEPS+1][NUM_LANES];
    logic signed [ZW-1:0] w_z [CORDIC_STEPS+1][NUM_LANES];

    // fold each angle into [-pi/2, pi/2) by adding pi; negate results later
    always_comb begin
        logic [ANG_W-1:0] ang;
        for (int l = 0; l < NUM_LANES; l++) begin
            if (l < MAX_JOINTS) begin
                ang = i_s_tdata[ANG_W*l +: ANG_W] + r_dh[l % MAX_JOINTS][63:48];
            end else begin
                ang = r_dh[l % MAX_JOINTS][31:16];
            end
            w_flip[0][l] = ang[15] ^ ang[14];
            ang[15]      = ang[15] ^ w_flip[0][l];
            w_z[0][l]    = ZW'(signed'(ang));
            w_x[0][l]    = CORDIC_GAIN;
            w_y[0][l]    = '0;
        end
        w_cctl[0].valid  = i_s_tvalid;
        w_cctl[0].frames = (r_frames > 3'(NUM_JOINTS)) ? 3'(NUM_JOINTS) : r_frames;
    end

    for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cordic
        dhfk_cordic_cell #(.STEP(g)) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_en   (en),
            .i_ctl  (w_cctl[g]),
            .i_flip (w_flip[g]),
            .i_x    (w_x[g]),
            .i_y    (w_y[g]),
            .i_z    (w_z[g]),
            .o_ctl  (w_cctl[g+1]),
            .o_flip (w_flip[g+1]),
            .o_x    (w_x[g+1]),
            .o_y    (w_y[g+1]),
            .o_z    (w_z[g+1])
        );
    end

    // ---------------- trig rounding stage ----------------
    t_ctl                 r_trig_ctl;
    logic signed [TW-1:0] r_sin [NUM_LANES];
    logic signed [TW-1:0] r_cos [NUM_LANES];
    logic signed [TW-1:0] n_sin [NUM_LANES];
    logic signed [TW-1:0] n_cos [NUM_LANES];

    always_comb begin
        logic signed [XW-1:0] sv, cv;
        for (int l = 0; l < NUM_LANES; l++) begin
            sv = (w_y[CORDIC_STEPS][l] + HALF_C) >>> RS;
            cv = (w_x[CORDIC_STEPS][l] + HALF_C) >>> RS;
            n_sin[l] = w_flip[CORDIC_STEPS][l] ? -sv[TW-1:0] : sv[TW-1:0];
            n_cos[l] = w_flip[CORDIC_STEPS][l] ? -cv[TW-1:0] : cv[TW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_trig_ctl <= '0;
        end else if (en) begin
            r_trig_ctl <= w_cctl[CORDIC_STEPS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sin <= n_sin;
            r_cos <= n_cos;
        end
    end

    // ---------------- joint chain ----------------
    t_ctl                 w_jctl [NUM_JOINTS+1];
    logic signed [TW-1:0] w_t  [NUM_JOINTS+1][9];
    logic signed [PW-1:0] w_p  [NUM_JOINTS+1][3];
    logic signed [TW-1:0] w_st [NUM_JOINTS+1][MAX_JOINTS];
    logic signed [TW-1:0] w_ct [NUM_JOINTS+1][MAX_JOINTS];
    logic signed [TW-1:0] w_sa [NUM_JOINTS+1][MAX_JOINTS];
    logic signed [TW-1:0] w_ca [NUM_JOINTS+1][MAX_JOINTS];

    always_comb begin
        w_jctl[0] = r_trig_ctl;
        for (int e = 0; e < 9; e++) begin
            w_t[0][e] = (e % 4 == 0) ? ONE : '0;   // identity
        end
        for (int r = 0; r < 3; r++) begin
            w_p[0][r] = '0;
        end
        for (int j = 0; j < MAX_JOINTS; j++) begin
            w_st[0][j] = r_sin[j];
            w_ct[0][j] = r_cos[j];
            w_sa[0][j] = r_sin[MAX_JOINTS + j];
            w_ca[0][j] = r_cos[MAX_JOINTS + j];
        end
    end

    for (genvar g = 0; g < NUM_JOINTS; g++) begin : g_joint
        dhfk_joint_cell #(.FRAC_BITS(FRAC_BITS), .JOINT(g)) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_en   (en),
            .i_ctl  (w_jctl[g]),
            .i_a    (signed'(r_dh[g][15:0])),
            .i_d    (signed'(r_dh[g][47:32])),
            .i_t    (w_t[g]),
            .i_p    (w_p[g]),
            .i_st   (w_st[g]),
            .i_ct   (w_ct[g]),
            .i_sa   (w_sa[g]),
            .i_ca   (w_ca[g]),
            .o_ctl  (w_jctl[g+1]),
            .o_t    (w_t[g+1]),
            .o_p    (w_p[g+1]),
            .o_st   (w_st[g+1]),
            .o_ct   (w_ct[g+1]),
            .o_sa   (w_sa[g+1]),
            .o_ca   (w_ca[g+1])
        );
    end

    // ---------------- output scaling and saturation ----------------
    logic signed [VW-1:0] w_v [9];

    for (genvar e = 0; e < 9; e++) begin : g_scale
        if (FRAC_BITS > 14) begin : g_down
            localparam logic signed [VW-1:0] HALF_O = VW'(1) <<< (FRAC_BITS - 15);
            assign w_v[e] = (VW'(w_t[NUM_JOINTS][e]) + HALF_O) >>> (FRAC_BITS - 14);
        end else begin : g_up
            assign w_v[e] = VW'(w_t[NUM_JOINTS][e]) <<< (14 - FRAC_BITS);
        end
    end

    logic [OUT_W-1:0] n_data;

    always_comb begin
        logic signed [15:0] rv;
        logic signed [18:0] pv;
        n_data = '0;
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                if (w_v[3*r+c] > VW'(16384)) begin
                    rv = 16'sd16384;
                end else if (w_v[3*r+c] < -VW'(16384)) begin
                    rv = -16'sd16384;
                end else begin
                    rv = w_v[3*r+c][15:0];
                end
                n_data[67*r + 16*c +: 16] = rv;
            end
            if (w_p[NUM_JOINTS][r] > PW'(262143)) begin
                pv = 19'sd262143;
            end else if (w_p[NUM_JOINTS][r] < -PW'(262144)) begin
                pv = -19'sd262144;
            end else begin
                pv = w_p[NUM_JOINTS][r][18:0];
            end
            n_data[67*r + 48 +: 19] = pv;
        end
    end

    logic [OUT_W-1:0] r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= w_jctl[NUM_JOINTS].valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_data <= n_data;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

    // ---------------- checks ----------------
    a_trig_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        en && w_cctl[CORDIC_STEPS].valid |=> r_trig_ctl.valid)
        else $error("trig stage dropped a beat");

    a_out_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("output valid right after reset");

    a_hold_when_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !en |=> $stable(r_trig_ctl) && $stable(r_out_data))
        else $error("pipeline moved while stalled");

    a_rot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> ($signed(o_m_tdata[15:0]) <= 16'sd16384) &&
                       ($signed(o_m_tdata[15:0]) >= -16'sd16384))
        else $error("rot_00 out of range");

endmodule
